/* hw/rtl/thve_pkg.sv */
// package for the text header value extractor
// item types, parser phase codes, register indexes and constants
// no dependencies
package thve_pkg;

  localparam int NAME_CHARS   = 16;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);
  localparam int NAME_POS_W   = 5;
  localparam int VAL_CNT_W    = 10;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_IDX_W    = 2;

  localparam logic [63:0]           RST_NAME_LOW  = 64'd4198561212057542979;
  localparam logic [63:0]           RST_NAME_HIGH = 64'd0;
  localparam logic [NAME_POS_W-1:0] RST_NAME_LEN  = 5'd8;
  localparam logic [VAL_CNT_W-1:0]  RST_MAX_VAL   = 10'd1020;

  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [1:0] MAX_SPACES = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NAME_LOW  = 2'd0,
    REG_NAME_HIGH = 2'd1,
    REG_NAME_LEN  = 2'd2,
    REG_MAX_VAL   = 2'd3
  } cfg_reg_t;

  typedef enum logic [4:0] {
    PH_WAIT     = 5'b00001,
    PH_MATCH    = 5'b00010,
    PH_SPACES   = 5'b00100,
    PH_VALUE    = 5'b01000,
    PH_FINISHED = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [7:0] value_byte;
    logic       byte_valid;
    logic       value_done;
    logic       found;
  } out_item_t;

endpackage

/* hw/rtl/thve_front.sv */
// front part: configuration registers and the per-byte header parser
// produces at most one result item per accepted input item
// depends on thve_pkg
module thve_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           acc,
  input  thve_pkg::in_item_t             in_item,
  input  logic                           cfg_wr_en,
  input  logic [thve_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [thve_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           res_valid,
  output thve_pkg::out_item_t            res_item
);
  import thve_pkg::*;

  logic [63:0]            name_low_r;
  logic [63:0]            name_high_r;
  logic [NAME_POS_W-1:0]  name_len_r;
  logic [VAL_CNT_W-1:0]   max_val_r;

  phase_t                 phase_r, phase_nxt;
  logic [NAME_POS_W-1:0]  pos_r, pos_nxt;
  logic [1:0]             spaces_r, spaces_nxt;
  logic [VAL_CNT_W-1:0]   vcnt_r, vcnt_nxt;

  logic [127:0]           name_all;
  logic [7:0]             name_c;
  logic [7:0]             name_flip;
  logic [NAME_POS_W-1:0]  eff_len;
  logic [NAME_POS_W-1:0]  pos_inc;
  logic [7:0]             b;
  logic                   emit;
  logic                   found;

  assign name_all = {name_high_r, name_low_r};
  assign b        = in_item.data_byte;
  assign pos_inc  = pos_r + NAME_POS_W'(1);

  always_comb begin
    name_c = pos_r[4] ? 8'd0 : name_all[pos_r[3:0]*8 +: 8];
    if (name_c > 8'd64 && name_c < 8'd91) begin
      name_flip = name_c + 8'd32;
    end else if (name_c > 8'd96 && name_c < 8'd123) begin
      name_flip = name_c - 8'd32;
    end else begin
      name_flip = name_c;
    end
    if (name_len_r == '0) begin
      eff_len = NAME_POS_W'(1);
    end else if (name_len_r > NAME_POS_W'(NAME_CHARS)) begin
      eff_len = NAME_POS_W'(NAME_CHARS);
    end else begin
      eff_len = name_len_r;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    spaces_nxt = spaces_r;
    vcnt_nxt   = vcnt_r;
    emit       = 1'b0;
    case (phase_r)
      PH_MATCH: begin
        if (b == name_c || b == name_flip) begin
          pos_nxt = pos_inc;
          if (pos_inc >= eff_len) begin
            phase_nxt  = PH_SPACES;
            spaces_nxt = 2'd0;
          end
        end else if (b == CH_LF) begin
          pos_nxt = '0;
        end else begin
          phase_nxt = PH_WAIT;
          pos_nxt   = '0;
        end
      end
      PH_SPACES, PH_VALUE: begin
        if (phase_r == PH_SPACES && b == CH_SPACE && spaces_r < MAX_SPACES) begin
          spaces_nxt = spaces_r + 2'd1;
        end else if (b == CH_CR || b == CH_LF || vcnt_r >= max_val_r) begin
          phase_nxt = PH_FINISHED;
        end else begin
          phase_nxt = PH_VALUE;
          emit      = 1'b1;
          vcnt_nxt  = vcnt_r + VAL_CNT_W'(1);
        end
      end
      PH_FINISHED: begin
        phase_nxt = PH_FINISHED;
      end
      default: begin
        phase_nxt = PH_WAIT;
        if (b == CH_LF) begin
          phase_nxt = PH_MATCH;
          pos_nxt   = '0;
        end
      end
    endcase
  end

  assign found = (phase_nxt == PH_SPACES) || (phase_nxt == PH_VALUE) ||
                 (phase_nxt == PH_FINISHED);

  assign res_valid           = acc && (emit || in_item.end_of_message);
  assign res_item.value_byte = emit ? b : 8'd0;
  assign res_item.byte_valid = emit;
  assign res_item.value_done = in_item.end_of_message;
  assign res_item.found      = found;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_low_r  <= RST_NAME_LOW;
      name_high_r <= RST_NAME_HIGH;
      name_len_r  <= RST_NAME_LEN;
      max_val_r   <= RST_MAX_VAL;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_NAME_LOW:  name_low_r  <= cfg_data;
        REG_NAME_HIGH: name_high_r <= cfg_data;
        REG_NAME_LEN:  name_len_r  <= cfg_data[NAME_POS_W-1:0];
        REG_MAX_VAL:   max_val_r   <= cfg_data[VAL_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_WAIT;
      pos_r    <= '0;
      spaces_r <= '0;
      vcnt_r   <= '0;
    end else if (acc) begin
      if (in_item.end_of_message) begin
        phase_r  <= PH_WAIT;
        pos_r    <= '0;
        spaces_r <= '0;
        vcnt_r   <= '0;
      end else begin
        phase_r  <= phase_nxt;
        pos_r    <= pos_nxt;
        spaces_r <= spaces_nxt;
        vcnt_r   <= vcnt_nxt;
      end
    end
  end

  a_eom_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_item.end_of_message |=> phase_r == PH_WAIT && pos_r == '0 && vcnt_r == '0)
    else $error("state not cleared after message end");

  a_emit_found: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_item.byte_valid |-> res_item.found)
    else $error("value byte without found");

  a_no_value_before_match: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_WAIT || phase_r == PH_MATCH) |-> vcnt_r == '0 && !emit)
    else $error("value count set outside value phase");

  a_finished_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_FINISHED && !in_item.end_of_message |-> !res_valid)
    else $error("result after value finished");

endmodule

/* hw/rtl/thve_fifo.sv */
// back part: short result queue between the parser and the output channel
// the head item is shown while the queue is not empty
// depends on thve_pkg
module thve_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  thve_pkg::out_item_t wr_item,
  input  logic                rd_en,
  output thve_pkg::out_item_t rd_item,
  output logic                full,
  output logic                empty
);
  import thve_pkg::*;

  out_item_t               mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_r;
  logic [FIFO_PTR_W-1:0]   rd_ptr_r;
  logic [FIFO_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                    do_wr;
  logic                    do_rd;

  assign full    = (cnt_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_item = mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + FIFO_CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + FIFO_PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !full)
    else $error("write into full queue");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("queue count out of range");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    FIFO_PTR_W'(wr_ptr_r - rd_ptr_r) == cnt_r[FIFO_PTR_W-1:0])
    else $error("queue pointers and count disagree");

endmodule

/* hw/rtl/text_header_value_extractor_unit.sv */
// top level of the text header value extractor
// joins the parser front part and the result queue
// depends on thve_pkg, thve_front, thve_fifo
//
// The block takes one message byte per clock cycle: the parser decides each
// byte combinationally and writes at most one result item into a four-entry
// result queue, so bytes stream back to back while the queue has room. full
// rises only when the queue holds four undelivered results; an accepted byte's
// result is registered in the queue before it shows on out_data. Configuration
// writes take effect at once and are meant to happen between messages while
// the queue is drained.
module text_header_value_extractor_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  thve_pkg::in_item_t              in_data,
  output logic                            empty,
  input  logic                            pop,
  output thve_pkg::out_item_t             out_data,
  input  logic                            cfg_wr_en,
  input  logic [thve_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [thve_pkg::CFG_DATA_W-1:0] cfg_data
);
  import thve_pkg::*;

  logic      acc;
  logic      res_valid;
  out_item_t res_item;

  assign acc = push && !full;

  thve_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .in_item   (in_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res_item  (res_item)
  );

  thve_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_valid),
    .wr_item (res_item),
    .rd_en   (pop),
    .rd_item (out_data),
    .full    (full),
    .empty   (empty)
  );

endmodule
